// ===== rtl/hrf_pkg.sv =====
// Shared types, constants and name tables for the HTTP response header framer.
package hrf_pkg;

    // Default widths of the internal counters
    localparam int LENGTH_BITS_DEF       = 32;
    localparam int HEADER_COUNT_BITS_DEF = 16;

    // Result field widths
    localparam int KIND_W   = 2;
    localparam int BODY_W   = 32;
    localparam int HDRLEN_W = 16;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Body framing kinds
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHUNKED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd2;

    // Name lengths and the name position limit
    localparam logic [4:0] LEN_NAME_LEN = 5'd14;
    localparam logic [4:0] ENC_NAME_LEN = 5'd17;
    localparam logic [4:0] NAME_POS_MAX = 5'd31;

    // Character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // One classified input beat as it waits in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       sor;
        logic       last;
        logic       is_colon;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic       is_blank;
        logic [3:0] digit;
    } t_beat;

    // Character of "Content-Length" at a name position
    function automatic logic [7:0] len_name_char(input logic [4:0] pos);
        logic [7:0] c;
        unique case (pos)
            5'd0:    c = 8'h43; // C
            5'd1:    c = 8'h6F; // o
            5'd2:    c = 8'h6E; // n
            5'd3:    c = 8'h74; // t
            5'd4:    c = 8'h65; // e
            5'd5:    c = 8'h6E; // n
            5'd6:    c = 8'h74; // t
            5'd7:    c = 8'h2D; // -
            5'd8:    c = 8'h4C; // L
            5'd9:    c = 8'h65; // e
            5'd10:   c = 8'h6E; // n
            5'd11:   c = 8'h67; // g
            5'd12:   c = 8'h74; // t
            5'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Character of "Transfer-Encoding" at a name position
    function automatic logic [7:0] enc_name_char(input logic [4:0] pos);
        logic [7:0] c;
        unique case (pos)
            5'd0:    c = 8'h54; // T
            5'd1:    c = 8'h72; // r
            5'd2:    c = 8'h61; // a
            5'd3:    c = 8'h6E; // n
            5'd4:    c = 8'h73; // s
            5'd5:    c = 8'h66; // f
            5'd6:    c = 8'h65; // e
            5'd7:    c = 8'h72; // r
            5'd8:    c = 8'h2D; // -
            5'd9:    c = 8'h45; // E
            5'd10:   c = 8'h6E; // n
            5'd11:   c = 8'h63; // c
            5'd12:   c = 8'h6F; // o
            5'd13:   c = 8'h64; // d
            5'd14:   c = 8'h69; // i
            5'd15:   c = 8'h6E; // n
            5'd16:   c = 8'h67; // g
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hrf_front.sv =====
// Front end: accepts input beats and classifies each byte for the parser.
module hrf_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data,
    input  logic          i_sor,
    input  logic          i_last,
    input  logic          i_queue_full,
    output logic          o_push,
    output hrf_pkg::t_beat o_beat
);
    import hrf_pkg::*;

    // A beat is taken whenever the queue has room.
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Byte classes that the parser needs.
    always_comb begin
        o_beat.data     = i_data;
        o_beat.sor      = i_sor;
        o_beat.last     = i_last;
        o_beat.is_colon = (i_data == CH_COLON);
        o_beat.is_cr    = (i_data == CH_CR);
        o_beat.is_lf    = (i_data == CH_LF);
        o_beat.is_digit = (i_data >= CH_ZERO) && (i_data <= CH_NINE);
        o_beat.is_blank = (i_data == CH_SPACE) || (i_data == CH_TAB);
        o_beat.digit    = i_data[3:0];
    end

endmodule

// ===== rtl/hrf_queue.sv =====
// Short queue of classified beats between the front end and the parser.
module hrf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hrf_pkg::t_beat i_beat,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output hrf_pkg::t_beat o_beat
);
    import hrf_pkg::*;

    t_beat               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/hrf_back.sv =====
// Back end: header parser state, length accumulator and the result register.
module hrf_back #(
    parameter int LENGTH_BITS       = hrf_pkg::LENGTH_BITS_DEF,
    parameter int HEADER_COUNT_BITS = hrf_pkg::HEADER_COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  hrf_pkg::t_beat              i_beat,
    output logic                        o_pop,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [hrf_pkg::KIND_W-1:0]  o_kind,
    output logic [hrf_pkg::BODY_W-1:0]  o_body_length,
    output logic [hrf_pkg::HDRLEN_W-1:0] o_header_length,
    output logic                        o_complete,
    output logic                        o_overflow
);
    import hrf_pkg::*;

    // Per-line parse state
    typedef struct packed {
        logic       in_value;
        logic [4:0] pos;
        logic       m_len;
        logic       m_enc;
        logic       has_content;
        logic       prev_cr;
    } t_line;

    localparam t_line LINE_CLEAR = '{in_value: 1'b0, pos: 5'd0, m_len: 1'b1,
                                     m_enc: 1'b1, has_content: 1'b0, prev_cr: 1'b0};

    t_line                        r_line, n_line;
    logic [KIND_W-1:0]            r_kind, n_kind;
    logic [LENGTH_BITS-1:0]       r_acc, n_acc;
    logic                         r_taken, n_taken;
    logic [HEADER_COUNT_BITS-1:0] r_count, n_count;
    logic                         r_done, n_done;
    logic                         r_sat, n_sat;

    logic                         r_res_valid;
    logic [KIND_W-1:0]            r_kind_out;
    logic [BODY_W-1:0]            r_body_out;
    logic [HDRLEN_W-1:0]          r_hdr_out;
    logic                         r_complete_out;
    logic                         r_overflow_out;

    logic                         emit;
    logic                         complete;
    logic [LENGTH_BITS+3:0]       acc_x10;
    logic [LENGTH_BITS+BODY_W-1:0]        body_ext;
    logic [HEADER_COUNT_BITS+HDRLEN_W-1:0] count_ext;

    // A beat leaves the queue when the result register is free or draining.
    assign o_pop = i_valid && (!r_res_valid || i_res_ready);

    // Parse one byte: a start beat clears the state first, a pending CR is
    // applied as a line byte, then the byte itself.
    always_comb begin
        t_line c;
        c        = r_line;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_taken  = r_taken;
        n_count  = r_count;
        n_done   = r_done;
        n_sat    = r_sat;
        complete = 1'b0;
        emit     = 1'b0;
        acc_x10  = '0;

        if (i_beat.sor) begin
            c       = LINE_CLEAR;
            n_kind  = KIND_UNKNOWN;
            n_acc   = '0;
            n_taken = 1'b0;
            n_count = '0;
            n_done  = 1'b0;
            n_sat   = 1'b0;
        end

        if (!n_done) begin
            // Saturating header byte count.
            if (n_count == {HEADER_COUNT_BITS{1'b1}}) begin
                n_sat = 1'b1;
            end else begin
                n_count = n_count + 1'b1;
            end

            if (c.prev_cr && i_beat.is_lf) begin
                // CR LF ends a line, or the header section if the line is empty.
                if (!c.has_content) begin
                    n_done   = 1'b1;
                    complete = 1'b1;
                end else begin
                    if (c.in_value && c.m_len) begin
                        n_taken = 1'b1;
                    end
                    c = LINE_CLEAR;
                end
            end else begin
                // A lone CR is an ordinary byte that never matches a name
                // character and always ends a number.
                if (c.prev_cr) begin
                    c.prev_cr     = 1'b0;
                    c.has_content = 1'b1;
                    if (!c.in_value) begin
                        c.m_len = 1'b0;
                        c.m_enc = 1'b0;
                        if (c.pos != NAME_POS_MAX) begin
                            c.pos = c.pos + 1'b1;
                        end
                    end else if (c.m_len && !n_taken) begin
                        c.m_len = 1'b0;
                    end
                end

                if (i_beat.is_cr) begin
                    c.prev_cr = 1'b1;
                end else begin
                    c.has_content = 1'b1;
                    if (!c.in_value) begin
                        if (i_beat.is_colon) begin
                            // Name ends: exact full-length match decides the kind.
                            c.in_value = 1'b1;
                            if (c.m_len && c.pos == LEN_NAME_LEN) begin
                                if (n_kind != KIND_CHUNKED) begin
                                    n_kind = KIND_LENGTH;
                                end
                            end else begin
                                c.m_len = 1'b0;
                            end
                            if (c.m_enc && c.pos == ENC_NAME_LEN) begin
                                n_kind = KIND_CHUNKED;
                            end
                            c.m_enc = 1'b0;
                            c.pos   = '0;
                        end else begin
                            if (c.pos >= LEN_NAME_LEN ||
                                len_name_char(c.pos) != i_beat.data) begin
                                c.m_len = 1'b0;
                            end
                            if (c.pos >= ENC_NAME_LEN ||
                                enc_name_char(c.pos) != i_beat.data) begin
                                c.m_enc = 1'b0;
                            end
                            if (c.pos != NAME_POS_MAX) begin
                                c.pos = c.pos + 1'b1;
                            end
                        end
                    end else if (c.m_len && !n_taken) begin
                        if (i_beat.is_digit) begin
                            // Multiply by ten and add, saturating on carry out.
                            c.pos   = 5'd1;
                            acc_x10 = ({4'b0, n_acc} << 3) + ({4'b0, n_acc} << 1)
                                    + (LENGTH_BITS+4)'(i_beat.digit);
                            if (acc_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) begin
                                n_acc = {LENGTH_BITS{1'b1}};
                                n_sat = 1'b1;
                            end else begin
                                n_acc = acc_x10[LENGTH_BITS-1:0];
                            end
                        end else if (i_beat.is_blank && c.pos == 5'd0) begin
                            c.pos = c.pos;
                        end else begin
                            c.m_len = 1'b0;
                        end
                    end
                end
            end

            emit = complete || i_beat.last;
        end
        n_line = c;
    end

    assign body_ext  = {{BODY_W{1'b0}}, n_acc};
    assign count_ext = {{HDRLEN_W{1'b0}}, n_count};

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= LINE_CLEAR;
            r_kind  <= KIND_UNKNOWN;
            r_acc   <= '0;
            r_taken <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_sat   <= 1'b0;
        end else if (o_pop) begin
            r_line  <= n_line;
            r_kind  <= n_kind;
            r_acc   <= n_acc;
            r_taken <= n_taken;
            r_count <= n_count;
            r_done  <= n_done;
            r_sat   <= n_sat;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind_out     <= n_kind;
            r_body_out     <= (n_kind == KIND_LENGTH) ? body_ext[BODY_W-1:0] : '0;
            r_hdr_out      <= count_ext[HDRLEN_W-1:0];
            r_complete_out <= complete;
            r_overflow_out <= n_sat;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_kind          = r_kind_out;
    assign o_body_length   = r_body_out;
    assign o_header_length = r_hdr_out;
    assign o_complete      = r_complete_out;
    assign o_overflow      = r_overflow_out;

endmodule

// ===== rtl/http_response_header_framer_top.sv =====
// Top level of the HTTP response header framer.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata = data_byte[7:0]; tuser = start_of_response; tlast = last_in_buffer
// m_axis    out  tdata = body_length[31:0], header_length[47:32];
//                tuser = body_kind[1:0], header_complete[2], count_overflow[3]
//
// One byte is taken per cycle while the beat queue has room. An accepted byte is
// written into the beat queue; the parser takes it from the queue when the result
// register is free or draining, and loads the result register from it.
// The rate is set by the parser loop, which updates the line state and the
// multiply-by-ten length accumulator once per cycle while it can pop a beat.
// A four-beat queue lets input continue while a result waits to be taken.
// Reset is synchronous and active low; it clears the queue, parser and result valid.
module http_response_header_framer_top #(
    parameter int LENGTH_BITS       = hrf_pkg::LENGTH_BITS_DEF,
    parameter int HEADER_COUNT_BITS = hrf_pkg::HEADER_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic        i_s_axis_tuser,  // [0] start_of_response
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // [31:0] body_length, [47:32] header_length
    output logic [3:0]  o_m_axis_tuser   // [1:0] body_kind, [2] header_complete,
                                         // [3] count_overflow
);
    import hrf_pkg::*;

    t_beat               front_beat;
    t_beat               queue_beat;
    logic                push;
    logic                queue_full;
    logic                queue_valid;
    logic                pop;
    logic [KIND_W-1:0]   kind;
    logic [BODY_W-1:0]   body_length;
    logic [HDRLEN_W-1:0] header_length;
    logic                complete;
    logic                overflow;

    // Byte classification and input handshake.
    hrf_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .i_sor        (i_s_axis_tuser),
        .i_last       (i_s_axis_tlast),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_beat       (front_beat)
    );

    // Beat queue.
    hrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (front_beat),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_beat  (queue_beat)
    );

    // Header parser and result register.
    hrf_back #(
        .LENGTH_BITS       (LENGTH_BITS),
        .HEADER_COUNT_BITS (HEADER_COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (queue_valid),
        .i_beat          (queue_beat),
        .o_pop           (pop),
        .o_res_valid     (o_m_axis_tvalid),
        .i_res_ready     (i_m_axis_tready),
        .o_kind          (kind),
        .o_body_length   (body_length),
        .o_header_length (header_length),
        .o_complete      (complete),
        .o_overflow      (overflow)
    );

    assign o_m_axis_tdata = {header_length, body_length};
    assign o_m_axis_tuser = {overflow, complete, kind};

endmodule

// ===== rtl/hrf_checker.sv =====
// Port-level checks on the header framer results, bound to the top level.
module hrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser
);
    import hrf_pkg::*;

    // No result is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // The body length is zero unless the body is framed by a length header.
    a_length_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] != KIND_LENGTH |->
            o_m_axis_tdata[31:0] == '0)
        else $error("body length without length framing");

    // A finished header holds at least the CR LF of the blank line.
    a_complete_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2] |-> o_m_axis_tdata[47:32] >= 16'd2)
        else $error("complete header shorter than a blank line");

endmodule

bind http_response_header_framer_top hrf_checker u_hrf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
